@@ rtl/adcs_pkg.sv @@
// shared types and constants of the adc scan bus sequencer
package adcs_pkg;

    // input word mode codes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_CHAR = 2'd1;
    localparam logic [1:0] MODE_BUS  = 2'd2;

    // result kinds
    localparam logic [3:0] KIND_START     = 4'd0;
    localparam logic [3:0] KIND_WRITE     = 4'd1;
    localparam logic [3:0] KIND_READ_ACK  = 4'd2;
    localparam logic [3:0] KIND_READ_NACK = 4'd3;
    localparam logic [3:0] KIND_STOP      = 4'd4;
    localparam logic [3:0] KIND_SAMPLES   = 4'd5;
    localparam logic [3:0] KIND_ERROR     = 4'd6;
    localparam logic [3:0] KIND_ENABLE    = 4'd7;
    localparam logic [3:0] KIND_PERIOD    = 4'd8;

    // serial command characters
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_TWO  = 8'h32;

    // scan periods in milliseconds
    localparam logic [13:0] PERIOD_FAST  = 14'd100;
    localparam logic [13:0] PERIOD_MID   = 14'd500;
    localparam logic [13:0] PERIOD_SLOW  = 14'd10000;

    // bus constants
    localparam logic [6:0] ADDR_RESET = 7'h50;
    localparam logic [7:0] CTRL_BASE  = 8'h80;

    typedef enum logic
    {
        APP_WAIT,
        APP_SCAN
    } app_phase_t;

    typedef enum logic [2:0]
    {
        BUS_IDLE,
        BUS_ADDR_W,
        BUS_CTRL,
        BUS_ADDR_R,
        BUS_HIGH,
        BUS_LOW
    } bus_phase_t;

    typedef enum logic [1:0]
    {
        CMD_NONE,
        CMD_S,
        CMD_C,
        CMD_M
    } cmd_t;

    typedef struct packed
    {
        logic [1:0] mode;
        logic [7:0] rx_char;
        logic       bus_ack;
        logic [7:0] bus_data;
    } adcs_in_t;

    typedef struct packed
    {
        logic [3:0]  kind;
        logic [7:0]  bus_byte;
        logic [11:0] sample_x;
        logic [11:0] sample_y;
        logic [11:0] sample_z;
        logic [13:0] echo_value;
        logic        last;
    } adcs_out_t;

    typedef struct packed
    {
        logic [6:0] device_address;
    } adcs_cfg_t;

    // one result before serialization
    typedef struct packed
    {
        logic [3:0]  kind;
        logic [7:0]  bus_byte;
        logic [13:0] echo_value;
    } adcs_entry_t;

    // all results caused by one input word
    typedef struct packed
    {
        logic [1:0]            count;
        adcs_entry_t [2:0]     entry;
        logic [11:0]           sample_x;
        logic [11:0]           sample_y;
        logic [11:0]           sample_z;
    } adcs_group_t;

endpackage

@@ rtl/adcs_stream_if.sv @@
// valid/ready channel carrying one payload word
interface adcs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/adcs_seq_core.sv @@
// sequencer state and per-word result generation
module adcs_seq_core #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  adcs_pkg::adcs_in_t  item,
    input  logic                cfg_we,
    input  adcs_pkg::adcs_cfg_t cfg_word,
    output adcs_pkg::adcs_group_t group
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] CH_LIMIT = 8'(NUM_CHANNELS);
    localparam logic [CH_W:0] CH_COUNT = (CH_W + 1)'(NUM_CHANNELS);

    // state registers
    logic [6:0]                addr_reg;
    adcs_pkg::app_phase_t      app_reg, app_next;
    adcs_pkg::bus_phase_t      bus_reg, bus_next;
    logic [CH_W-1:0]           ch_reg, ch_next;
    logic [13:0]               ms_reg, ms_next;
    logic [13:0]               period_reg, period_next;
    logic                      en_reg, en_next;
    logic                      pend_reg, pend_next;
    logic                      held_reg, held_next;
    adcs_pkg::cmd_t            code_reg, code_next;
    logic [7:0]                high_reg, high_next;
    logic [11:0]               store_reg [NUM_CHANNELS];

    // decode signals
    logic [13:0]    ms_inc;
    logic           tick_hit;
    logic           pend_now;
    logic           is_tick, is_char, is_bus;
    logic           tick_start, cmd_take, cmd_exec;
    logic           s_exec, c_exec, m_start;
    logic           bus_act, ack_fail, low_done, more;
    logic           start_chan;
    logic [7:0]     digit;
    logic [CH_W:0]  ch_plus;
    logic [11:0]    new_sample;
    logic           store_wr;
    logic [11:0]    sample_view [3];
    logic [7:0]     addr_w_byte, addr_r_byte;
    logic [7:0]     c;

    // event decode
    always_comb
    begin
        c          = item.rx_char;
        ms_inc     = ms_reg + 14'd1;
        tick_hit   = ms_inc >= period_reg;
        pend_now   = pend_reg || tick_hit;
        is_tick    = step && (item.mode == adcs_pkg::MODE_TICK);
        is_char    = step && (item.mode == adcs_pkg::MODE_CHAR);
        is_bus     = step && (item.mode == adcs_pkg::MODE_BUS);
        tick_start = is_tick && (app_reg == adcs_pkg::APP_WAIT) && en_reg && pend_now;
        cmd_take   = is_char && !held_reg
                     && (c == adcs_pkg::CHAR_S || c == adcs_pkg::CHAR_C
                         || c == adcs_pkg::CHAR_M);
        cmd_exec   = is_char && held_reg;
        s_exec     = cmd_exec && (code_reg == adcs_pkg::CMD_S);
        c_exec     = cmd_exec && (code_reg == adcs_pkg::CMD_C);
        digit      = c - adcs_pkg::CHAR_ZERO;
        m_start    = cmd_exec && (code_reg == adcs_pkg::CMD_M)
                     && (app_reg == adcs_pkg::APP_WAIT)
                     && (c >= adcs_pkg::CHAR_ZERO) && (digit < CH_LIMIT);
        bus_act    = is_bus && (app_reg == adcs_pkg::APP_SCAN);
        ack_fail   = bus_act && !item.bus_ack
                     && (bus_reg == adcs_pkg::BUS_ADDR_W || bus_reg == adcs_pkg::BUS_CTRL
                         || bus_reg == adcs_pkg::BUS_ADDR_R);
        low_done   = bus_act && (bus_reg == adcs_pkg::BUS_LOW);
        ch_plus    = (CH_W + 1)'(ch_reg) + (CH_W + 1)'(1);
        more       = ch_plus < CH_COUNT;
        start_chan = tick_start || m_start || (low_done && more);
        new_sample = {high_reg, item.bus_data[7:4]};
        store_wr   = low_done && ((CH_W + 1)'(ch_reg) < CH_COUNT);
        addr_w_byte = {addr_reg, 1'b0};
        addr_r_byte = {addr_reg, 1'b1};
    end

    // sample values as seen after this word
    for (genvar i = 0; i < 3; i++)
    begin : g_view
        if (i < NUM_CHANNELS)
        begin : g_live
            assign sample_view[i] = (store_wr && ch_reg == CH_W'(i)) ? new_sample
                                                                        : store_reg[i];
        end
        else
        begin : g_absent
            assign sample_view[i] = 12'd0;
        end
    end

    // next state
    always_comb
    begin
        app_next    = app_reg;
        bus_next    = bus_reg;
        ch_next     = ch_reg;
        ms_next     = ms_reg;
        period_next = period_reg;
        en_next     = en_reg;
        pend_next   = pend_reg;
        held_next   = held_reg;
        code_next   = code_reg;
        high_next   = high_reg;

        if (is_tick)
        begin
            ms_next   = tick_hit ? 14'd0 : ms_inc;
            pend_next = pend_now;
            if (tick_start)
            begin
                pend_next = 1'b0;
                ch_next   = '0;
            end
        end

        if (cmd_take)
        begin
            held_next = 1'b1;
            unique case (c)
                adcs_pkg::CHAR_S: code_next = adcs_pkg::CMD_S;
                adcs_pkg::CHAR_C: code_next = adcs_pkg::CMD_C;
                default:          code_next = adcs_pkg::CMD_M;
            endcase
        end

        if (cmd_exec)
        begin
            held_next = 1'b0;
        end
        if (s_exec)
        begin
            en_next = (c == adcs_pkg::CHAR_ONE);
        end
        if (c_exec)
        begin
            case (c)
                adcs_pkg::CHAR_ZERO: period_next = adcs_pkg::PERIOD_FAST;
                adcs_pkg::CHAR_ONE:  period_next = adcs_pkg::PERIOD_MID;
                adcs_pkg::CHAR_TWO:  period_next = adcs_pkg::PERIOD_SLOW;
                default:             period_next = period_reg;
            endcase
        end
        if (m_start)
        begin
            ch_next = digit[CH_W-1:0];
        end

        if (bus_act)
        begin
            unique case (bus_reg)
                adcs_pkg::BUS_ADDR_W: bus_next = adcs_pkg::BUS_CTRL;
                adcs_pkg::BUS_CTRL:   bus_next = adcs_pkg::BUS_ADDR_R;
                adcs_pkg::BUS_ADDR_R: bus_next = adcs_pkg::BUS_HIGH;
                adcs_pkg::BUS_HIGH:
                begin
                    high_next = item.bus_data;
                    bus_next  = adcs_pkg::BUS_LOW;
                end
                adcs_pkg::BUS_LOW:
                begin
                    if (more)
                    begin
                        ch_next = ch_plus[CH_W-1:0];
                    end
                    else
                    begin
                        app_next = adcs_pkg::APP_WAIT;
                        bus_next = adcs_pkg::BUS_IDLE;
                    end
                end
                default:
                begin
                    app_next = adcs_pkg::APP_WAIT;
                    bus_next = adcs_pkg::BUS_IDLE;
                end
            endcase
            if (ack_fail)
            begin
                app_next = adcs_pkg::APP_WAIT;
                bus_next = adcs_pkg::BUS_IDLE;
            end
        end

        // a new channel always restarts at the address write
        if (start_chan)
        begin
            app_next = adcs_pkg::APP_SCAN;
            bus_next = adcs_pkg::BUS_ADDR_W;
        end
    end

    // results of this word
    always_comb
    begin
        group          = '0;
        group.sample_x = sample_view[0];
        group.sample_y = sample_view[1];
        group.sample_z = sample_view[2];

        if (low_done)
        begin
            group.entry[0].kind = adcs_pkg::KIND_STOP;
            if (more)
            begin
                group.count             = 2'd3;
                group.entry[1].kind     = adcs_pkg::KIND_START;
                group.entry[2].kind     = adcs_pkg::KIND_WRITE;
                group.entry[2].bus_byte = addr_w_byte;
            end
            else
            begin
                group.count         = 2'd2;
                group.entry[1].kind = adcs_pkg::KIND_SAMPLES;
            end
        end
        else if (start_chan)
        begin
            group.count             = 2'd2;
            group.entry[0].kind     = adcs_pkg::KIND_START;
            group.entry[1].kind     = adcs_pkg::KIND_WRITE;
            group.entry[1].bus_byte = addr_w_byte;
        end
        else if (ack_fail)
        begin
            group.count         = 2'd2;
            group.entry[0].kind = adcs_pkg::KIND_STOP;
            group.entry[1].kind = adcs_pkg::KIND_ERROR;
        end
        else if (s_exec)
        begin
            group.count               = 2'd1;
            group.entry[0].kind       = adcs_pkg::KIND_ENABLE;
            group.entry[0].echo_value = {13'd0, en_next};
        end
        else if (c_exec)
        begin
            group.count               = 2'd1;
            group.entry[0].kind       = adcs_pkg::KIND_PERIOD;
            group.entry[0].echo_value = period_next;
        end
        else if (bus_act)
        begin
            case (bus_reg)
                adcs_pkg::BUS_ADDR_W:
                begin
                    group.count             = 2'd1;
                    group.entry[0].kind     = adcs_pkg::KIND_WRITE;
                    group.entry[0].bus_byte = adcs_pkg::CTRL_BASE | 8'(ch_reg);
                end
                adcs_pkg::BUS_CTRL:
                begin
                    group.count             = 2'd2;
                    group.entry[0].kind     = adcs_pkg::KIND_START;
                    group.entry[1].kind     = adcs_pkg::KIND_WRITE;
                    group.entry[1].bus_byte = addr_r_byte;
                end
                adcs_pkg::BUS_ADDR_R:
                begin
                    group.count         = 2'd1;
                    group.entry[0].kind = adcs_pkg::KIND_READ_ACK;
                end
                adcs_pkg::BUS_HIGH:
                begin
                    group.count         = 2'd1;
                    group.entry[0].kind = adcs_pkg::KIND_READ_NACK;
                end
                default:
                begin
                    group.count = 2'd0;
                end
            endcase
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= adcs_pkg::ADDR_RESET;
            app_reg    <= adcs_pkg::APP_WAIT;
            bus_reg    <= adcs_pkg::BUS_IDLE;
            ch_reg     <= '0;
            ms_reg     <= 14'd0;
            period_reg <= adcs_pkg::PERIOD_MID;
            en_reg     <= 1'b1;
            pend_reg   <= 1'b0;
            held_reg   <= 1'b0;
            code_reg   <= adcs_pkg::CMD_NONE;
            high_reg   <= 8'd0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= 12'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                addr_reg <= cfg_word.device_address;
            end
            app_reg    <= app_next;
            bus_reg    <= bus_next;
            ch_reg     <= ch_next;
            ms_reg     <= ms_next;
            period_reg <= period_next;
            en_reg     <= en_next;
            pend_reg   <= pend_next;
            held_reg   <= held_next;
            code_reg   <= code_next;
            high_reg   <= high_next;
            if (store_wr)
            begin
                store_reg[ch_reg] <= new_sample;
            end
        end
    end

endmodule

@@ rtl/adcs_out_queue.sv @@
// result register that hands out up to three results one word at a time
module adcs_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  adcs_pkg::adcs_group_t group,
    output logic                  can_load,
    adcs_stream_if.source         res
);

    adcs_pkg::adcs_group_t grp_reg;
    logic [1:0]            idx_reg;
    logic                  busy_reg;
    logic                  is_last;
    logic                  fire;
    adcs_pkg::adcs_entry_t cur;
    logic                  show_samples;

    // current word
    always_comb
    begin
        cur          = grp_reg.entry[idx_reg];
        is_last      = (idx_reg + 2'd1) == grp_reg.count;
        fire         = busy_reg && res.ready;
        can_load     = !busy_reg || (fire && is_last);
        show_samples = cur.kind == adcs_pkg::KIND_SAMPLES;
    end

    // output drive
    always_comb
    begin
        res.valid           = busy_reg;
        res.data.kind       = cur.kind;
        res.data.bus_byte   = cur.bus_byte;
        res.data.sample_x   = show_samples ? grp_reg.sample_x : 12'd0;
        res.data.sample_y   = show_samples ? grp_reg.sample_y : 12'd0;
        res.data.sample_z   = show_samples ? grp_reg.sample_z : 12'd0;
        res.data.echo_value = cur.echo_value;
        res.data.last       = is_last;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= group;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= group.count != 2'd0;
            idx_reg  <= 2'd0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

@@ rtl/adc_scan_bus_sequencer.sv @@
// adc scan bus sequencer top level
// Takes one event word per cycle (millisecond tick, serial character or bus response) into an
// input register while the result queue can take it, works it out combinationally into a
// result register and hands the results out one word per cycle while res is ready, with last
// marking the final one of each event. An event with k results (k from 0 to 3) holds the result
// register until its last result is taken, and the next event is loaded from the input register
// in the same cycle as that is taken (at once if it had none); its first result shows from then.
// The device_address register is written through cfg, which is always ready.
module adc_scan_bus_sequencer #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    adcs_stream_if.sink   evt,
    adcs_stream_if.sink   cfg,
    adcs_stream_if.source res
);

    logic                  evt_valid_reg;
    adcs_pkg::adcs_in_t    evt_item_reg;
    logic                  can_load;
    logic                  step;
    adcs_pkg::adcs_group_t group;
    logic                  cfg_we;

    // handshakes
    always_comb
    begin
        step      = evt_valid_reg && can_load;
        evt.ready = !evt_valid_reg || can_load;
        cfg.ready = 1'b1;
        cfg_we    = cfg.valid;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (evt.valid && evt.ready)
        begin
            evt_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            evt_item_reg <= evt.data;
        end
    end

    adcs_seq_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (evt_item_reg),
        .cfg_we   (cfg_we),
        .cfg_word (cfg.data),
        .group    (group)
    );

    adcs_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .group    (group),
        .can_load (can_load),
        .res      (res)
    );

endmodule
